@@ src/sta_pkg.sv @@
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants of the sine tone adder
// Beat types, register codes and the elaboration-time sine table builder.
// ----------------------------------------------------------------------------
package sta_pkg;

  // table and sample geometry
  localparam int TABLE_BITS  = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int TBL_SIZE    = 1 << TABLE_BITS;
  localparam int QUARTER     = TBL_SIZE / 4;
  localparam int PHASE_W     = 32;
  localparam int COUNT_W     = 16;
  localparam int AMP_W       = 16;
  localparam int SINE_W      = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  // queue depths (powers of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  // pi in Q62
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_PHASE_OFFSET  = 3'd1,
    REG_AMPLITUDE     = 3'd2,
    REG_PERIOD_LENGTH = 3'd3
  } reg_idx_t;

  // configuration register set
  typedef struct packed {
    logic        [PHASE_W-1:0] phase_step;
    logic        [PHASE_W-1:0] phase_offset;
    logic signed [AMP_W-1:0]   amplitude;
    logic        [COUNT_W-1:0] period_length;
  } cfg_t;

  // one classified beat from front to back
  typedef struct packed {
    logic        [TABLE_BITS-1:0]  addr;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } work_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [TBL_SIZE];

  // (a*b) >> 62 over the full product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // round(32767*sin(pi*r/(2*QUARTER))), Taylor series in Q62
  function automatic logic signed [SINE_W-1:0] quarter_sine(input int r);
    logic [63:0] lowmask;
    logic [63:0] rr;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] den;
    logic [63:0] scaled;
    lowmask = (64'd1 << (TABLE_BITS - 1)) - 64'd1;
    rr      = 64'(r);
    x       = (PI_Q62 >> (TABLE_BITS - 1)) * rr
            + (((PI_Q62 & lowmask) * rr) >> (TABLE_BITS - 1));
    x2      = mul_q62(x, x);
    term    = x;
    total   = x;
    for (int n = 1; n < 15; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      term = udiv64(mul_q62(term, x2), den);
      if ((n % 2) == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    scaled = mul_q62(total, 64'd32767 << 40);
    return SINE_W'((scaled + (64'd1 << 39)) >> 40);
  endfunction

  // full-turn table from quarter-wave symmetry
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t             rom;
    int                    q;
    int                    r;
    logic signed [SINE_W-1:0] v;
    for (int k = 0; k < TBL_SIZE; k++) begin
      q = k / QUARTER;
      r = k % QUARTER;
      v = ((q % 2) == 1) ? quarter_sine(QUARTER - r) : quarter_sine(r);
      rom[k] = ((q / 2) % 2 == 1) ? -v : v;
    end
    return rom;
  endfunction

endpackage

@@ src/sine_tone_adder.sv @@
// ----------------------------------------------------------------------------
// sine_tone_adder: adds a table sine tone to a sample stream
// Top level: configuration registers, front end, work queue and back end.
// ----------------------------------------------------------------------------
// One sample per clock is taken and one result per clock is given when both
// sides keep moving. A beat reaches the result ports through the work queue,
// the registered sine table read and the registered amplitude multiplier,
// then it lands in the result buffer. The front end's phase accumulator
// steps once per accepted beat, so throughput is set by the one-beat-per-clock
// issue from the work queue into the table and multiplier stages. The user
// must write registers only while the block is idle, which the block does not
// enforce; a new phase offset is used at the next restart beat or period wrap.
// ----------------------------------------------------------------------------
module sine_tone_adder import sta_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_restart,
  input  logic                          in_last_in,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  output logic                          out_last_out
);

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_empty;
  work_t q_data, q_head;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    cfg_r.phase_step    <= cfg_wdata[PHASE_W-1:0];
        REG_PHASE_OFFSET:  cfg_r.phase_offset  <= cfg_wdata[PHASE_W-1:0];
        REG_AMPLITUDE:     cfg_r.amplitude     <= cfg_wdata[AMP_W-1:0];
        REG_PERIOD_LENGTH: cfg_r.period_length <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  sta_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample_in (in_sample_in),
    .in_restart   (in_restart),
    .in_last_in   (in_last_in),
    .q_push       (q_push),
    .q_data       (q_data),
    .q_full       (q_full)
  );

  sta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sta_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .amplitude      (cfg_r.amplitude),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_last_out   (out_last_out)
  );

endmodule

@@ src/sta_front.sv @@
// ----------------------------------------------------------------------------
// sta_front: phase front end
// Accepts input beats, applies restarts, steps the phase accumulator and the
// period counter, and hands the table address with the sample to the queue.
// ----------------------------------------------------------------------------
module sta_front import sta_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_restart,
  input  logic                          in_last_in,
  output logic                          q_push,
  output work_t                         q_data,
  input  logic                          q_full
);

  logic [PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PHASE_W-1:0] phase_use;
  logic [COUNT_W-1:0] count_use;
  logic [COUNT_W:0]   count_inc;
  logic               wrap;
  logic               accept;

  // handshake, blocked while reset is asserted
  assign in_full = q_full | ~rst_n;
  assign accept  = in_push & ~in_full;
  assign q_push  = accept;

  // restart takes effect before this sample
  assign phase_use = in_restart ? cfg.phase_offset : phase_acc_r;
  assign count_use = in_restart ? '0 : count_r;
  assign count_inc = {1'b0, count_use} + {{COUNT_W{1'b0}}, 1'b1};

  // period restart once the count reaches the period length
  assign wrap = (cfg.period_length != '0) && (count_inc >= {1'b0, cfg.period_length});

  assign phase_acc_nxt = wrap ? cfg.phase_offset : phase_use + cfg.phase_step;
  assign count_nxt     = wrap ? '0 : count_inc[COUNT_W-1:0];

  // beat for the back end
  assign q_data.addr   = phase_use[PHASE_W-1 -: TABLE_BITS];
  assign q_data.sample = in_sample_in;
  assign q_data.last   = in_last_in;

  // phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      count_r     <= '0;
    end else if (accept) begin
      phase_acc_r <= phase_acc_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

@@ src/sta_queue.sv @@
// ----------------------------------------------------------------------------
// sta_queue: work queue between front and back
// Small circular buffer of classified beats; lets either side stall alone.
// ----------------------------------------------------------------------------
module sta_queue import sta_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t head,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ src/sta_back.sv @@
// ----------------------------------------------------------------------------
// sta_back: tone back end
// Sine table read, amplitude multiply, add with saturation, and the result
// buffer. Issue from the queue is credit-based, so the stages never stall.
// ----------------------------------------------------------------------------
module sta_back import sta_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [AMP_W-1:0]       amplitude,
  input  work_t                         q_head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  output logic                          out_last_out
);

  localparam int PROD_W = AMP_W + SINE_W;
  localparam int TONE_W = PROD_W - 15;
  localparam int SUM_W  = ((SAMPLE_BITS > TONE_W) ? SAMPLE_BITS : TONE_W) + 1;
  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CRED_W = PTR_W + 2;
  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
    logic                          last;
  } res_t;

  // stage registers
  logic                          v1_r, v2_r;
  logic signed [SINE_W-1:0]      sine_r;
  logic signed [SAMPLE_BITS-1:0] smp1_r, smp2_r;
  logic                          last1_r, last2_r;
  logic signed [PROD_W-1:0]      prod_r;

  // result buffer
  res_t             buf_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  logic                    issue;
  logic [CRED_W-1:0]       in_use;
  logic signed [TONE_W-1:0] tone;
  logic signed [SUM_W-1:0]  sum;
  res_t                    res;
  logic                    do_pop;

  // issue only with room for every beat in flight
  assign in_use = CRED_W'(cnt_r) + CRED_W'(v1_r) + CRED_W'(v2_r);
  assign issue  = ~q_empty & (in_use < CRED_W'(OUT_DEPTH));
  assign q_pop  = issue;

  // table read and multiply
  always_ff @(posedge clk) begin
    sine_r  <= SINE_ROM[q_head.addr];
    smp1_r  <= q_head.sample;
    last1_r <= q_head.last;
    prod_r  <= PROD_W'(amplitude) * PROD_W'(sine_r);
    smp2_r  <= smp1_r;
    last2_r <= last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  // floor shift, add and saturate
  assign tone = prod_r[PROD_W-1:15];
  assign sum  = SUM_W'(smp2_r) + SUM_W'(tone);

  always_comb begin
    res.last = last2_r;
    priority if (sum > SAT_HI) begin
      res.sample  = SAT_HI[SAMPLE_BITS-1:0];
      res.clipped = 1'b1;
    end else if (sum < SAT_LO) begin
      res.sample  = SAT_LO[SAMPLE_BITS-1:0];
      res.clipped = 1'b1;
    end else begin
      res.sample  = sum[SAMPLE_BITS-1:0];
      res.clipped = 1'b0;
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (v2_r) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign do_pop    = out_pop & ~out_empty;
  assign out_empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (v2_r)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (v2_r && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !v2_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // head beat
  assign out_sample_out = buf_r[rd_ptr_r].sample;
  assign out_clipped    = buf_r[rd_ptr_r].clipped;
  assign out_last_out   = buf_r[rd_ptr_r].last;

endmodule

@@ src/sta_checker.sv @@
// ----------------------------------------------------------------------------
// sta_checker: port-level checks of the sine tone adder
// Reset behaviour, result hold under back-pressure and saturation flagging.
// ----------------------------------------------------------------------------
module sta_checker import sta_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [CFG_IDX_W-1:0]          cfg_index,
  input logic [CFG_DATA_W-1:0]         cfg_wdata,
  input logic                          in_push,
  input logic                          in_full,
  input logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input logic                          in_restart,
  input logic                          in_last_in,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_clipped,
  input logic                          out_last_out
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results pending after reset");

  // input side ready again once reset is released
  a_reset_ready: assert property (@(posedge clk) (!rst_n ##1 rst_n) |-> !in_full)
    else $error("input side full after reset");

  // a waiting result is not lost or changed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sample_out)
      && $stable(out_clipped) && $stable(out_last_out)))
    else $error("waiting result changed");

  // a clipped beat sits on a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_clipped) |-> (out_sample_out == S_MAX || out_sample_out == S_MIN))
    else $error("clipped flag without saturated sample");

endmodule

bind sine_tone_adder sta_checker u_sta_checker (.*);

@@ verif/tone_mix_checker.sv @@
// ----------------------------------------------------------------------------
// tone_mix_checker: result predictor and comparator for the sine tone adder
// Watches the register port and both beat channels, keeps its own phase
// accumulator, sample counter and sine table, and compares each result beat
// field by field against the oldest expected mix.
// ----------------------------------------------------------------------------
module tone_mix_checker import sta_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_restart,
  input  logic                          in_last_in,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          out_clipped,
  input  logic                          out_last_out,
  output int                            mismatches,
  output int                            pending
);

  localparam int SAT_HI     = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO     = -SAT_HI - 1;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
    logic                          last;
  } mix_beat_t;

  logic signed [SINE_W-1:0] sine_lut [TBL_SIZE];

  // shadow registers and tone state
  logic [PHASE_W-1:0]      step_q;
  logic [PHASE_W-1:0]      offset_q;
  logic signed [AMP_W-1:0] amp_q;
  logic [COUNT_W-1:0]      period_q;
  logic [PHASE_W-1:0]      phase_q;
  logic [COUNT_W-1:0]      count_q;

  mix_beat_t mix_due [$];

  // (a*b) >> 62 of a Q62 by Q62 product, kept to 64 bits
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return wide[125:62];
  endfunction

  // quarter wave point by odd power series in Q62, rounded to Q15
  function automatic int quarter_wave(input int r);
    logic [63:0] lowmask;
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] scaled;
    int          n;
    lowmask  = (64'd1 << (TABLE_BITS - 1)) - 64'd1;
    angle    = (PI_Q62 >> (TABLE_BITS - 1)) * 64'(r)
             + (((PI_Q62 & lowmask) * 64'(r)) >> (TABLE_BITS - 1));
    angle_sq = q62_mul(angle, angle);
    term     = angle;
    acc      = angle;
    for (n = 1; n < 15; n++) begin
      term = q62_mul(term, angle_sq) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    scaled = q62_mul(acc, 64'd32767 << 40);
    return int'((scaled + (64'd1 << 39)) >> 40);
  endfunction

  // full turn from the quarter wave
  initial begin : fill_lut
    int k;
    int q;
    int r;
    int v;
    for (k = 0; k < TBL_SIZE; k++) begin
      q = k / QUARTER;
      r = k % QUARTER;
      v = (q % 2 == 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
      sine_lut[k] = SINE_W'(((q / 2) % 2 == 1) ? -v : v);
    end
  end

  // one accepted sample: apply a restart, mix, saturate, then move the phase on
  task automatic mix_beat(input logic signed [SAMPLE_BITS-1:0] smp,
                          input logic restart_bit, input logic last_bit,
                          output mix_beat_t res);
    int prod;
    int tone;
    int total;
    if (restart_bit) begin
      phase_q = offset_q;
      count_q = '0;
    end
    prod  = int'(amp_q) * int'(sine_lut[phase_q[PHASE_W-1 -: TABLE_BITS]]);
    tone  = prod >>> 15;
    total = int'(smp) + tone;
    res.clip = 1'b0;
    if (total > SAT_HI) begin
      total    = SAT_HI;
      res.clip = 1'b1;
    end
    if (total < SAT_LO) begin
      total    = SAT_LO;
      res.clip = 1'b1;
    end
    res.sample = SAMPLE_BITS'(total);
    res.last   = last_bit;
    // period restart, also when the period was shortened below the count
    if (period_q != '0 && int'(count_q) + 1 >= int'(period_q)) begin
      phase_q = offset_q;
      count_q = '0;
    end else begin
      phase_q = phase_q + step_q;
      count_q = count_q + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    mix_beat_t got;
    mix_beat_t want;
    if (!rst_n) begin
      step_q   = '0;
      offset_q = '0;
      amp_q    = '0;
      period_q = '0;
      phase_q  = '0;
      count_q  = '0;
      mix_due.delete();
      mismatches <= 0;
    end else begin
      // register writes, unknown index ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP:    step_q   = cfg_wdata[PHASE_W-1:0];
          REG_PHASE_OFFSET:  offset_q = cfg_wdata[PHASE_W-1:0];
          REG_AMPLITUDE:     amp_q    = cfg_wdata[AMP_W-1:0];
          REG_PERIOD_LENGTH: period_q = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (out_pop && !out_empty) begin
        got.sample = out_sample_out;
        got.clip   = out_clipped;
        got.last   = out_last_out;
        if (mix_due.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("[%0t] result beat with nothing expected: sample %0d clipped %0b last %0b",
                     $time, got.sample, got.clip, got.last);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = mix_due.pop_front();
          if (got.sample !== want.sample || got.clip !== want.clip ||
              got.last !== want.last) begin
            if (mismatches < REPORT_MAX) begin
              $display("[%0t] mismatch: expected sample %0d clipped %0b last %0b, got sample %0d clipped %0b last %0b",
                       $time, want.sample, want.clip, want.last,
                       got.sample, got.clip, got.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      // input beat
      if (in_push && !in_full) begin
        mix_beat(in_sample_in, in_restart, in_last_in, want);
        mix_due.push_back(want);
      end
    end
    pending <= mix_due.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for the sine tone adder
// Drives register settings and sample beats under changing flow control; a
// checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
  import sta_pkg::*;

  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int SEND_IDLE_PCT [4] = '{0, 61, 0, 19};
  localparam int POP_STALL_PCT [4] = '{0, 0, 61, 19};

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index    = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata    = '0;
  logic                          in_push      = 1'b0;
  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          in_restart   = 1'b0;
  logic                          in_last_in   = 1'b0;
  logic                          out_empty;
  logic                          out_pop      = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          out_clipped;
  logic                          out_last_out;

  int send_idle    = 0;
  int pop_stall    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;

  sine_tone_adder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .in_last_in     (in_last_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_last_out   (out_last_out)
  );

  tone_mix_checker mix_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_in   (in_sample_in),
    .in_restart     (in_restart),
    .in_last_in     (in_last_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_last_out   (out_last_out),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // clock
  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall);
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample beat, with optional idle cycles ahead of it
  task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic rs, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_sample_in <= smp;
    in_restart   <= rs;
    in_last_in   <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // register write, enable left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set, junk in the unused upper bits of the narrow ones, and an optional write to an unused index
  task automatic program_regs(input logic [PHASE_W-1:0] step,
                              input logic [PHASE_W-1:0] offset,
                              input logic signed [AMP_W-1:0] amp,
                              input logic [COUNT_W-1:0] period,
                              input logic stray);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_PHASE_OFFSET, offset);
    write_reg(REG_AMPLITUDE, {16'($urandom), amp});
    write_reg(REG_PERIOD_LENGTH, {16'($urandom), period});
    if (stray) begin
      write_reg(CFG_IDX_W'(REG_PERIOD_LENGTH) + CFG_IDX_W'($urandom_range(1, 4)), $urandom);
    end
    cfg_we <= 1'b0;
  endtask

  // wait until every expected result is out and the pipeline is quiet
  task automatic drain_block;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [PHASE_W-1:0]            step;
    logic [PHASE_W-1:0]            offset;
    logic signed [AMP_W-1:0]       amp;
    logic [COUNT_W-1:0]            period;
    logic signed [SAMPLE_BITS-1:0] smp;
    int                            p;
    int                            i;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // quarter-turn start, full positive amplitude: clip high
    program_regs(32'h0040_0000, 32'h4000_0000, 16'sh7FFF, 16'd0, 1'b1);
    send_beat(16'sh0000, 1'b1, 1'b0);
    send_beat(16'sh7FFF, 1'b0, 1'b0);
    send_beat(16'sh8000, 1'b0, 1'b1);
    send_beat(16'sh0001, 1'b0, 1'b0);
    send_beat(16'shFFFF, 1'b0, 1'b0);
    drain_block;

    // most negative amplitude on a negative sine, full step, short period
    program_regs(32'hFFFF_FFFF, 32'hC000_0000, 16'sh8000, 16'd3, 1'b0);
    send_beat(16'sh7FFF, 1'b1, 1'b0);
    send_beat(16'sh8000, 1'b0, 1'b0);
    send_beat(16'sh0000, 1'b0, 1'b0);
    send_beat(16'sd100, 1'b0, 1'b1);
    send_beat(16'sd5, 1'b0, 1'b0);
    drain_block;

    // continuous mode with negative products, count runs up
    program_regs(32'h1234_5678, 32'h0000_0000, -16'sd12345, 16'd0, 1'b0);
    send_beat(16'sh4000, 1'b1, 1'b0);
    for (i = 0; i < 5; i++) begin
      send_beat(16'($urandom), 1'b0, 1'(i == 4));
    end
    drain_block;

    // period cut below the count and new offset with no restart beat
    write_reg(REG_PHASE_OFFSET, 32'h8000_0000);
    write_reg(REG_PERIOD_LENGTH, {16'hFFFF, 16'd2});
    cfg_we <= 1'b0;
    for (i = 0; i < 4; i++) begin
      send_beat(16'($urandom), 1'b0, 1'(i == 3));
    end

    // random phases under each flow-control mode
    for (p = 0; p < N_PHASES; p++) begin
      drain_block;
      case ($urandom_range(5))
        0:       step = '0;
        1:       step = '1;
        2:       step = 32'h0040_0000 * $urandom_range(1, 64);
        default: step = $urandom;
      endcase
      case ($urandom_range(4))
        0:       offset = '0;
        1:       offset = '1;
        default: offset = $urandom;
      endcase
      case ($urandom_range(5))
        0:       amp = 16'sh7FFF;
        1:       amp = 16'sh8000;
        2:       amp = '0;
        default: amp = 16'($urandom);
      endcase
      if (p == 0) begin
        period = 16'd1;
      end else if (p == 1) begin
        period = 16'hFFFF;
      end else begin
        case ($urandom_range(5))
          1:       period = 16'($urandom_range(1, 12));
          2:       period = 16'($urandom_range(13, 300));
          3:       period = 16'($urandom);
          default: period = '0;
        endcase
      end
      program_regs(step, offset, amp, period, 1'($urandom_range(1)));
      send_idle = SEND_IDLE_PCT[p % 4];
      pop_stall = POP_STALL_PCT[p % 4];
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0:       smp = 16'sh7FFF;
          1:       smp = 16'sh8000;
          2:       smp = 16'(int'($urandom_range(64)) - 32);
          default: smp = 16'($urandom);
        endcase
        send_beat(smp, 1'($urandom_range(39) == 0), 1'($urandom_range(7) == 0));
      end
    end

    send_idle = 0;
    pop_stall = 0;
    drain_block;
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
